// ----- src/q2e_pkg.sv -----
package q2e_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int CORDIC_STAGES_DEF   = 16;

  // Square root steps over a radicand below or at 2^60: bit 2^60 down to 2^0
  localparam int SQRT_STEPS = 31;

  // Datapath width of the vectoring unit and of the square root
  localparam int DW = 64;

  // Arctangent of 2^-i, 32-bit binary angle with 2^31 equal to pi
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/q2e_front.sv -----
module q2e_front
  import q2e_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  output logic                              s1_valid,
  output logic                              s2_valid,
  output logic signed [DW-1:0]              roll_num,
  output logic signed [DW-1:0]              roll_den,
  output logic signed [DW-1:0]              yaw_num,
  output logic signed [DW-1:0]              yaw_den,
  output logic                              s3_clamped,
  output logic                              s4_valid,
  output logic        [DW-1:0]              s4_rad,
  output logic signed [31:0]                s4_t
);

  localparam int PW   = 2 * COMPONENT_WIDTH;
  localparam int PB   = 2 * (COMPONENT_WIDTH - 2) - 4;
  localparam int RSH  = (PB >= 30) ? PB - 30 : 0;
  localparam int LSH  = (PB < 30) ? 30 - PB : 0;
  localparam int NPR  = 10;

  localparam int IWW = 0, IXX = 1, IYY = 2, IZZ = 3, IWX = 4;
  localparam int IYZ = 5, IWZ = 6, IXY = 7, IWY = 8, IXZ = 9;

  logic signed [PW-1:0] prod [NPR];
  logic signed [DW-1:0] p1   [NPR];
  logic signed [DW-1:0] s2_s;
  logic                 s3_valid;
  logic signed [DW-1:0] s_cl;
  logic                 s_clamp;
  logic signed [DW-1:0] t_wide;
  logic signed [31:0]   s3_t;
  logic signed [DW-1:0] tsq;

  // Form all component products
  always_comb begin
    prod[IWW] = quat_w * quat_w;
    prod[IXX] = quat_x * quat_x;
    prod[IYY] = quat_y * quat_y;
    prod[IZZ] = quat_z * quat_z;
    prod[IWX] = quat_w * quat_x;
    prod[IYZ] = quat_y * quat_z;
    prod[IWZ] = quat_w * quat_z;
    prod[IXY] = quat_x * quat_y;
    prod[IWY] = quat_w * quat_y;
    prod[IXZ] = quat_x * quat_z;
  end

  // Stage 1: drop four fraction bits with floor rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    for (int k = 0; k < NPR; k++) begin
      p1[k] <= DW'(prod[k] >>> 4);
    end
  end

  // Stage 2: numerators and denominators
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    roll_num <= (p1[IWX] + p1[IYZ]) <<< 1;
    roll_den <= p1[IWW] - p1[IXX] - p1[IYY] + p1[IZZ];
    yaw_num  <= (p1[IWZ] + p1[IXY]) <<< 1;
    yaw_den  <= p1[IWW] + p1[IXX] - p1[IYY] - p1[IZZ];
    s2_s     <= (p1[IWY] - p1[IXZ]) <<< 1;
  end

  // Clamp the sine to one and bring it to thirty fraction bits
  always_comb begin
    s_cl    = s2_s;
    s_clamp = 1'b0;
    if (s2_s > (64'sd1 <<< PB)) begin
      s_cl    = 64'sd1 <<< PB;
      s_clamp = 1'b1;
    end else if (s2_s < -(64'sd1 <<< PB)) begin
      s_cl    = -(64'sd1 <<< PB);
      s_clamp = 1'b1;
    end
    t_wide = (s_cl >>> RSH) <<< LSH;
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_clamped <= s_clamp;
    s3_t       <= signed'(t_wide[31:0]);
  end

  assign tsq = s3_t * s3_t;

  // Stage 4: radicand for the cosine
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_rad <= 64'h1000_0000_0000_0000 - unsigned'(tsq);
    s4_t   <= s3_t;
  end

endmodule

// ----- src/q2e_sqrt.sv -----
module q2e_sqrt
  import q2e_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic        [DW-1:0] in_rad,
  input  logic signed [31:0]   in_t,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_c,
  output logic signed [DW-1:0] out_t
);

  logic                 vld [SQRT_STEPS+1];
  logic        [DW-1:0] rem [SQRT_STEPS+1];
  logic        [DW-1:0] res [SQRT_STEPS+1];
  logic signed [31:0]   tt  [SQRT_STEPS+1];

  assign vld[0] = in_valid;
  assign rem[0] = in_rad;
  assign res[0] = '0;
  assign tt[0]  = in_t;

  // One restoring step per stage, bit 2^60 downward
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [DW-1:0] trial;
    assign trial = res[k] + (64'd1 << (60 - 2 * k));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + (64'd1 << (60 - 2 * k));
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
      tt[k+1] <= tt[k];
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign out_c     = signed'({33'd0, res[SQRT_STEPS][30:0]});
  assign out_t     = DW'(tt[SQRT_STEPS]);

endmodule

// ----- src/q2e_vector.sv -----
module q2e_vector
  import q2e_pkg::*;
#(
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [DW-1:0]   in_y,
  input  logic signed [DW-1:0]   in_x,
  output logic                   out_valid,
  output logic [ANGLE_WIDTH-1:0] out_angle
);

  localparam int NS = 3;
  localparam int SH = 32 - ANGLE_WIDTH;

  logic                 nv [NS+1];
  logic                 nz [NS+1];
  logic signed [DW-1:0] nx [NS+1];
  logic signed [DW-1:0] ny [NS+1];
  logic        [DW-1:0] nm [NS+1];

  logic                 cv [CORDIC_STAGES+1];
  logic                 cz [CORDIC_STAGES+1];
  logic signed [DW-1:0] cx [CORDIC_STAGES+1];
  logic signed [DW-1:0] cy [CORDIC_STAGES+1];
  logic        [31:0]   ca [CORDIC_STAGES+1];

  logic [ANGLE_WIDTH-1:0] angle_rnd;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return (v < 0) ? unsigned'(-v) : unsigned'(v);
  endfunction

  assign nv[0] = in_valid;
  assign nz[0] = (in_x == 0) && (in_y == 0);
  assign nx[0] = in_x;
  assign ny[0] = in_y;
  assign nm[0] = mag(in_x) | mag(in_y);

  // Normalize: two binary shift steps per stage (32,16 | 8,4 | 2,1)
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int K1 = 32 >> (2 * j);
    localparam int K2 = K1 >> 1;
    logic signed [DW-1:0] x_a, y_a, x_b, y_b;
    logic        [DW-1:0] m_a, m_b;

    always_comb begin
      x_a = nx[j];
      y_a = ny[j];
      m_a = nm[j];
      if ((m_a >> (60 - K1)) == 0) begin
        x_a = x_a <<< K1;
        y_a = y_a <<< K1;
        m_a = m_a << K1;
      end
      x_b = x_a;
      y_b = y_a;
      m_b = m_a;
      if ((m_b >> (60 - K2)) == 0) begin
        x_b = x_b <<< K2;
        y_b = y_b <<< K2;
        m_b = m_b << K2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j+1] <= 1'b0;
      end else begin
        nv[j+1] <= nv[j];
      end
      nz[j+1] <= nz[j];
      nx[j+1] <= x_b;
      ny[j+1] <= y_b;
      nm[j+1] <= m_b;
    end
  end

  // Fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= nv[NS];
    end
    cz[0] <= nz[NS];
    if (nx[NS] < 0) begin
      if (ny[NS] >= 0) begin
        cx[0] <= ny[NS];
        cy[0] <= -nx[NS];
        ca[0] <= 32'h40000000;
      end else begin
        cx[0] <= -ny[NS];
        cy[0] <= nx[NS];
        ca[0] <= 32'hC0000000;
      end
    end else begin
      cx[0] <= nx[NS];
      cy[0] <= ny[NS];
      ca[0] <= 32'h0;
    end
  end

  // Micro-rotations toward the x axis, one per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      cz[i+1] <= cz[i];
      if (cy[i] >= 0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        ca[i+1] <= ca[i] + atan_entry(5'(i));
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        ca[i+1] <= ca[i] - atan_entry(5'(i));
      end
    end
  end

  // Round half up to the output width
  if (SH == 0) begin : g_full
    assign angle_rnd = ca[CORDIC_STAGES];
  end else begin : g_rnd
    logic [31:0] sum;
    assign sum       = ca[CORDIC_STAGES] + (32'd1 << (SH - 1));
    assign angle_rnd = sum[31:SH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cv[CORDIC_STAGES];
    end
    out_angle <= cz[CORDIC_STAGES] ? '0 : angle_rnd;
  end

endmodule

// ----- src/quaternion_to_euler_angles.sv -----
// Path from start to done: front stages, square root, then the pitch vectoring unit.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The 31-stage square root for the pitch path and the CORDIC stages set the latency.
// Reset (synchronous, active high) clears all valid bits; items in flight are dropped.
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  output logic                              done,
  output logic signed [ANGLE_WIDTH-1:0]     roll_x,
  output logic signed [ANGLE_WIDTH-1:0]     pitch_y,
  output logic signed [ANGLE_WIDTH-1:0]     yaw_z,
  output logic                              pitch_clamped
);

  localparam int L_VEC  = CORDIC_STAGES + 5;
  localparam int D_ANG  = SQRT_STEPS + 2;
  localparam int D_FLAG = SQRT_STEPS + L_VEC + 1;

  logic                   s1_valid, s2_valid, s4_valid, s3_clamped;
  logic signed [DW-1:0]   roll_num, roll_den, yaw_num, yaw_den;
  logic        [DW-1:0]   s4_rad;
  logic signed [31:0]     s4_t;
  logic                   sq_valid;
  logic signed [DW-1:0]   sq_c, sq_t;
  logic                   roll_valid, yaw_valid, pitch_valid;
  logic [ANGLE_WIDTH-1:0] roll_ang, yaw_ang, pitch_ang;
  logic [ANGLE_WIDTH-1:0] roll_dly [D_ANG];
  logic [ANGLE_WIDTH-1:0] yaw_dly  [D_ANG];
  logic                   flag_dly [D_FLAG];

  assign busy = 1'b0;

  q2e_front #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .s1_valid  (s1_valid),
    .s2_valid  (s2_valid),
    .roll_num  (roll_num),
    .roll_den  (roll_den),
    .yaw_num   (yaw_num),
    .yaw_den   (yaw_den),
    .s3_clamped(s3_clamped),
    .s4_valid  (s4_valid),
    .s4_rad    (s4_rad),
    .s4_t      (s4_t)
  );

  q2e_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s4_valid),
    .in_rad   (s4_rad),
    .in_t     (s4_t),
    .out_valid(sq_valid),
    .out_c    (sq_c),
    .out_t    (sq_t)
  );

  q2e_vector #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_roll (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_y     (roll_num),
    .in_x     (roll_den),
    .out_valid(roll_valid),
    .out_angle(roll_ang)
  );

  q2e_vector #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_y     (yaw_num),
    .in_x     (yaw_den),
    .out_valid(yaw_valid),
    .out_angle(yaw_ang)
  );

  q2e_vector #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_y     (sq_t),
    .in_x     (sq_c),
    .out_valid(pitch_valid),
    .out_angle(pitch_ang)
  );

  // Hold roll, yaw and the clamp flag until the pitch path catches up
  always_ff @(posedge clk) begin
    roll_dly[0] <= roll_ang;
    yaw_dly[0]  <= yaw_ang;
    flag_dly[0] <= s3_clamped;
    for (int k = 1; k < D_ANG; k++) begin
      roll_dly[k] <= roll_dly[k-1];
      yaw_dly[k]  <= yaw_dly[k-1];
    end
    for (int k = 1; k < D_FLAG; k++) begin
      flag_dly[k] <= flag_dly[k-1];
    end
  end

  assign done          = pitch_valid;
  assign roll_x        = signed'(roll_dly[D_ANG-1]);
  assign yaw_z         = signed'(yaw_dly[D_ANG-1]);
  assign pitch_y       = signed'(pitch_ang);
  assign pitch_clamped = flag_dly[D_FLAG-1];

  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst) start |=> s1_valid)
    else $error("accepted item missing from first stage");

  // Roll and yaw run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst) roll_valid == yaw_valid)
    else $error("roll and yaw paths out of step");

  // The pitch path picks up every item that leaves the front stages
  a_sqrt: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> ##(SQRT_STEPS) sq_valid)
    else $error("item lost in square root");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule
